// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker module abf_check.
// No dependencies; clock, reset and property come from the caller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ASSERT_ON_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/abf_pkg.sv -----
// Package for the angle bracket line framer: sizes, character codes,
// transaction structs and the control command between framer and emitter.
package abf_pkg;

    localparam int LINE_MAX = 64;
    localparam int ADDR_W   = $clog2(LINE_MAX);
    localparam int LEN_W    = $clog2(LINE_MAX + 1);

    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_MAX - 1);

    localparam logic [7:0] CH_LT = 8'h3C;
    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    typedef struct packed {
        logic       action;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       last_of_line;
    } out_item_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              emit;
        logic [LEN_W-1:0]  emit_len;
    } ctl_cmd_t;

endpackage

// ----- rtl/abf_ctl.sv -----
// Framer control: phase, frame length, idle tick counter and timeout register.
// Issues line memory writes and the emit request. Depends on abf_pkg.
module abf_ctl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  abf_pkg::in_item_t item,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data,
    output abf_pkg::ctl_cmd_t cmd
);
    import abf_pkg::*;

    localparam logic [1:0] PH_WAIT_START = 2'd0;
    localparam logic [1:0] PH_IN_FRAME   = 2'd1;
    localparam logic [1:0] PH_WAIT_LF    = 2'd2;

    logic [15:0]      timeout_reg;
    logic [1:0]       phase_reg, phase_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [15:0]      idle_reg, idle_next;
    logic [15:0]      idle_inc;
    logic [7:0]       b;

    assign b        = item.byte_value;
    assign idle_inc = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        len_next     = len_reg;
        idle_next    = idle_reg;
        cmd          = '0;
        cmd.wr_addr  = len_reg[ADDR_W-1:0];
        cmd.wr_data  = b;
        cmd.emit_len = len_reg;
        if (take)
        begin
            if (item.action == ACT_TICK)
            begin
                idle_next = idle_inc;
                if (phase_reg != PH_WAIT_START && idle_inc >= timeout_reg)
                begin
                    phase_next = PH_WAIT_START;
                    len_next   = '0;
                end
            end
            else
            begin
                idle_next = '0;
                if (b == CH_LT)
                begin
                    // '<' restarts the frame in every phase
                    cmd.wr_en   = 1'b1;
                    cmd.wr_addr = '0;
                    cmd.wr_data = CH_LT;
                    len_next    = LEN_W'(1);
                    phase_next  = PH_IN_FRAME;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_WAIT_START:
                        begin
                        end
                        PH_IN_FRAME:
                        begin
                            if (b == CH_CR || b == CH_LF || len_reg >= LEN_LIMIT)
                            begin
                                phase_next = PH_WAIT_START;
                                len_next   = '0;
                            end
                            else
                            begin
                                cmd.wr_en = 1'b1;
                                len_next  = len_reg + LEN_W'(1);
                                if (b == CH_GT)
                                    phase_next = PH_WAIT_LF;
                            end
                        end
                        PH_WAIT_LF:
                        begin
                            if (b != CH_CR)
                            begin
                                if (b == CH_LF && len_reg != '0 && len_reg < LEN_LIMIT)
                                    cmd.emit = 1'b1;
                                phase_next = PH_WAIT_START;
                                len_next   = '0;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_WAIT_START;
                            len_next   = '0;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            phase_reg   <= PH_WAIT_START;
            len_reg     <= '0;
            idle_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                timeout_reg <= cfg_wr_data;
            phase_reg <= phase_next;
            len_reg   <= len_next;
            idle_reg  <= idle_next;
        end
    end

endmodule

// ----- rtl/angle_bracket_line_framer_unit.sv -----
// Angle bracket line framer top level: line memory and frame emitter.
// Depends on abf_pkg and abf_ctl.
//
// Input channel in_valid/in_stall/in_item carries received bytes
// (action 0) and millisecond ticks (action 1). A frame '<'...'>' followed
// by CRs and an LF is sent on out_valid/out_stall/out_item, one transaction
// per byte, last_of_line on the '>'.
// An input transaction is taken whenever no frame is being sent.
// The LF that completes a frame starts the emitter: each byte is read
// from the line memory (EM_READ) and then shown on the output (EM_SHOW);
// the next byte is not read until the shown one is taken, and in_stall
// is high while the emitter is busy.
// out_stall holds the shown byte unchanged; the emitter waits.
// cfg_wr_en/cfg_wr_data write the idle timeout in ticks (reset 100).
// Reset returns to waiting for '<', clears the idle counter and out_valid
// (out_item is not reset); the line memory is not cleared.
module angle_bracket_line_framer_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  abf_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output abf_pkg::out_item_t out_item,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data
);
    import abf_pkg::*;

    localparam logic [1:0] EM_IDLE = 2'd0;
    localparam logic [1:0] EM_READ = 2'd1;
    localparam logic [1:0] EM_SHOW = 2'd2;

    logic [7:0]        line_mem [LINE_MAX];
    logic [7:0]        rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    logic [1:0]        em_reg, em_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;

    logic              take;
    logic              is_last;
    ctl_cmd_t          cmd;

    assign in_stall = (em_reg != EM_IDLE);
    assign take     = in_valid && !in_stall;
    assign is_last  = (LEN_W'(idx_reg) + LEN_W'(1)) == len_reg;

    abf_ctl u_ctl (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .item        (in_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd)
    );

    // writes only happen while idle, so a read never meets a pending write
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            line_mem[cmd.wr_addr] <= cmd.wr_data;
        if (rd_en)
            rd_data_reg <= line_mem[rd_addr];
    end

    always_comb
    begin
        em_next        = em_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        unique case (em_reg)
            EM_IDLE:
            begin
                if (cmd.emit)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = '0;
                    idx_next = '0;
                    len_next = cmd.emit_len;
                    em_next  = EM_READ;
                end
            end
            EM_READ:
            begin
                out_next.line_byte    = rd_data_reg;
                out_next.last_of_line = is_last;
                out_valid_next        = 1'b1;
                em_next               = EM_SHOW;
            end
            EM_SHOW:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (out_reg.last_of_line)
                        em_next = EM_IDLE;
                    else
                    begin
                        idx_next = idx_reg + ADDR_W'(1);
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + ADDR_W'(1);
                        em_next  = EM_READ;
                    end
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
                em_next        = EM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_reg        <= EM_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            em_reg        <= em_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        len_reg <= len_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ----- rtl/abf_check.sv -----
// Port checker for angle_bracket_line_framer_unit, attached by bind.
// Depends on abf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module abf_check (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input abf_pkg::out_item_t out_item
);

    `ASSERT_ON_RST(a_out_valid_held, clk, rst_n, out_valid && out_stall |=> out_valid, "result transaction withdrawn while stalled")
    `ASSERT_ON_RST(a_out_item_held, clk, rst_n, out_valid && out_stall |=> $stable(out_item), "result payload changed while stalled")
    `ASSERT_ON_RST(a_no_input_while_sending, clk, rst_n, out_valid |-> in_stall, "input taken while a frame is being sent")
    `ASSERT_ON_RST(a_idle_after_last, clk, rst_n, out_valid && !out_stall && out_item.last_of_line |=> !out_valid, "result shown after the last byte of a frame")
    `ASSERT_ALWAYS(a_quiet_in_reset, clk, !rst_n |-> !out_valid, "result valid during reset")

endmodule

bind angle_bracket_line_framer_unit abf_check u_abf_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
);
